// ===== rtl/q2r_pkg.sv =====
// ----------------------------------------------------------------------------
// q2r_pkg
// Shared types and constants for the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
package q2r_pkg;

    localparam int QW      = 16;        // quaternion component width
    localparam int MW      = 16;        // matrix entry width
    localparam int NW      = 33;        // squared norm width (max 2^32)
    localparam int PW      = 34;        // signed numerator width
    localparam int QBITS   = 15;        // quotient bits, magnitude <= 16384
    localparam int NENT    = 9;

    typedef struct packed {
        logic signed [QW-1:0] quat_w;
        logic signed [QW-1:0] quat_x;
        logic signed [QW-1:0] quat_y;
        logic signed [QW-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [MW-1:0] m00;
        logic signed [MW-1:0] m01;
        logic signed [MW-1:0] m02;
        logic signed [MW-1:0] m10;
        logic signed [MW-1:0] m11;
        logic signed [MW-1:0] m12;
        logic signed [MW-1:0] m20;
        logic signed [MW-1:0] m21;
        logic signed [MW-1:0] m22;
        logic                 zero_norm;
    } mat_t;

    // one division lane: sign, remainder, quotient bits so far
    typedef struct packed {
        logic              neg;
        logic [NW+1:0]     rem;
        logic [QBITS:0]    quo;
    } div_lane_t;

endpackage

// ===== rtl/q2r_front.sv =====
// ----------------------------------------------------------------------------
// q2r_front
// Products, squared norm and the nine numerators, two register stages.
// ----------------------------------------------------------------------------
module q2r_front
    import q2r_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  quat_t                in_q,
    output logic                 out_vld,
    output logic [NW-1:0]        norm,
    output logic [NENT*PW-1:0]   nums
);

    logic signed [2*QW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [2*QW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic                   v1_reg, v2_reg;
    logic [NW-1:0]          norm_reg;
    logic [NENT*PW-1:0]     nums_reg;
    logic signed [PW-1:0]   ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic [NENT*PW-1:0]     nums_next;

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: ten products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= in_q.quat_w * in_q.quat_w;
            xx_reg <= in_q.quat_x * in_q.quat_x;
            yy_reg <= in_q.quat_y * in_q.quat_y;
            zz_reg <= in_q.quat_z * in_q.quat_z;
            xy_reg <= in_q.quat_x * in_q.quat_y;
            xz_reg <= in_q.quat_x * in_q.quat_z;
            yz_reg <= in_q.quat_y * in_q.quat_z;
            wx_reg <= in_q.quat_w * in_q.quat_x;
            wy_reg <= in_q.quat_w * in_q.quat_y;
            wz_reg <= in_q.quat_w * in_q.quat_z;
        end
    end

    // sign extend; squares are non-negative (ww of -32768 is 2^30)
    assign ww = PW'(ww_reg);
    assign xx = PW'(xx_reg);
    assign yy = PW'(yy_reg);
    assign zz = PW'(zz_reg);
    assign xy = PW'(xy_reg);
    assign xz = PW'(xz_reg);
    assign yz = PW'(yz_reg);
    assign wx = PW'(wx_reg);
    assign wy = PW'(wy_reg);
    assign wz = PW'(wz_reg);

    // numerators
    always_comb
    begin
        nums_next[0*PW +: PW] = ww + xx - yy - zz;
        nums_next[1*PW +: PW] = (xy - wz) <<< 1;
        nums_next[2*PW +: PW] = (xz + wy) <<< 1;
        nums_next[3*PW +: PW] = (xy + wz) <<< 1;
        nums_next[4*PW +: PW] = ww - xx + yy - zz;
        nums_next[5*PW +: PW] = (yz - wx) <<< 1;
        nums_next[6*PW +: PW] = (xz - wy) <<< 1;
        nums_next[7*PW +: PW] = (yz + wx) <<< 1;
        nums_next[8*PW +: PW] = ww - xx - yy + zz;
    end

    // stage 2: norm and numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg <= NW'(ww + xx + yy + zz);
            nums_reg <= nums_next;
        end
    end

    assign out_vld = v2_reg;
    assign norm    = norm_reg;
    assign nums    = nums_reg;

endmodule

// ===== rtl/q2r_div.sv =====
// ----------------------------------------------------------------------------
// q2r_div
// Pipelined restoring divider, nine lanes sharing one denominator, one
// quotient bit per stage, then rounding and sign.
// ----------------------------------------------------------------------------
module q2r_div
    import q2r_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [NW-1:0]        norm,
    input  logic [NENT*PW-1:0]   nums,
    output logic                 out_vld,
    output mat_t                 out_m
);

    // quotient of 2*mag*16384 over 2N: compute floor(mag*32768/N)+1 >> 1,
    // i.e. round half up of mag*16384/N; QBITS+1 bits of quotient
    localparam int STG = QBITS + 1;

    div_lane_t       lane_reg [STG+1][NENT];
    logic [NW-1:0]   den_reg  [STG+1];
    logic            vld_reg  [STG+2];
    logic            zero_reg [STG+1];
    mat_t            m_reg;
    logic [MW-1:0]   ent_next [NENT];

    // stage 0 load, then long division stages, bit STG-1 first
    always_ff @(posedge clk)
    begin
        logic [NW+1:0] part;
        if (en)
        begin
            den_reg[0]  <= norm;
            zero_reg[0] <= (norm == '0);
            for (int i = 0; i < NENT; i++)
            begin
                lane_reg[0][i].neg <= nums[i*PW + PW-1];
                lane_reg[0][i].rem <= (NW+2)'(nums[i*PW + PW-1]
                    ? -$signed(nums[i*PW +: PW]) : $signed(nums[i*PW +: PW]));
                lane_reg[0][i].quo <= '0;
            end
            for (int s = 0; s < STG; s++)
            begin
                den_reg[s+1]  <= den_reg[s];
                zero_reg[s+1] <= zero_reg[s];
                for (int i = 0; i < NENT; i++)
                begin
                    // first stage takes the integer bit, later ones double
                    part = (s == 0) ? lane_reg[s][i].rem : (lane_reg[s][i].rem << 1);
                    lane_reg[s+1][i].neg <= lane_reg[s][i].neg;
                    if (part >= {2'b00, den_reg[s]})
                    begin
                        lane_reg[s+1][i].rem <= part - {2'b00, den_reg[s]};
                        lane_reg[s+1][i].quo <= {lane_reg[s][i].quo[QBITS-1:0], 1'b1};
                    end
                    else
                    begin
                        lane_reg[s+1][i].rem <= part;
                        lane_reg[s+1][i].quo <= {lane_reg[s][i].quo[QBITS-1:0], 1'b0};
                    end
                end
            end
        end
    end

    // rounding, sign and zero norm masking
    always_comb
    begin
        logic [QBITS+1:0] rnd;
        for (int i = 0; i < NENT; i++)
        begin
            rnd = {1'b0, lane_reg[STG][i].quo} + (QBITS+2)'(1);
            if (zero_reg[STG])
                ent_next[i] = '0;
            else if (lane_reg[STG][i].neg)
                ent_next[i] = -rnd[QBITS+1:1];
            else
                ent_next[i] = rnd[QBITS+1:1];
        end
    end

    // output stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg.m00       <= ent_next[0];
            m_reg.m01       <= ent_next[1];
            m_reg.m02       <= ent_next[2];
            m_reg.m10       <= ent_next[3];
            m_reg.m11       <= ent_next[4];
            m_reg.m12       <= ent_next[5];
            m_reg.m20       <= ent_next[6];
            m_reg.m21       <= ent_next[7];
            m_reg.m22       <= ent_next[8];
            m_reg.zero_norm <= zero_reg[STG];
        end
    end

    // valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STG+2; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < STG+2; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign out_vld = vld_reg[STG+1];
    assign out_m   = m_reg;

endmodule

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// pipeline: 2 + 1 + 16 + 1 register stages (front, load, divide, output)
// throughput: one quaternion per cycle into every stage while not stalled
// stall: a held output freezes all stages together, nothing lost
// reset: rst_n async active low clears all valid bits; data regs not reset
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// Normalized quaternion to Q1.14 rotation matrix with zero norm flag.
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix
    import q2r_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  quat_t  in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output mat_t   out_data
);

    logic                en;
    logic                f_vld;
    logic [NW-1:0]       f_norm;
    logic [NENT*PW-1:0]  f_nums;

    // whole pipe advances unless a valid result is held
    assign en       = out_ready || !out_valid;
    assign in_ready = en;

    q2r_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .in_q    (in_data),
        .out_vld (f_vld),
        .norm    (f_norm),
        .nums    (f_nums)
    );

    q2r_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (f_vld),
        .norm    (f_norm),
        .nums    (f_nums),
        .out_vld (out_valid),
        .out_m   (out_data)
    );

endmodule
